// ===== rtl/mptb_pkg.sv =====
package mptb_pkg;

  localparam int unsigned ChanW      = 8;
  localparam int unsigned ProdW      = 2 * ChanW;
  localparam int unsigned ColorW     = 3 * ChanW;
  localparam int unsigned NumLanes   = 3;
  localparam int unsigned LaneStages = 5;
  // lane stages plus the merge register
  localparam int unsigned PipeDepth  = LaneStages + 1;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = ColorW;

  localparam logic [ChanW-1:0] FullScale = 8'd255;
  localparam logic [ChanW-1:0] HalfRound = 8'd127;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPrimary   = 2'd0,
    CfgSecondary = 2'd1,
    CfgMaskEn    = 2'd2,
    CfgMode      = 2'd3
  } cfg_idx_e;

  // per-lane view of the configuration
  typedef struct packed {
    logic [ChanW-1:0] primary;
    logic [ChanW-1:0] secondary;
    logic             mask_en;
    logic             body_mode;
  } lane_cfg_t;

  // load enables, one per lane stage
  typedef struct packed {
    logic [LaneStages-1:0] ld;
  } lane_en_t;

  // floor((x + 127) / 255) for x up to 255*255
  function automatic logic [ChanW-1:0] div255_round(logic [ProdW-1:0] x);
    logic [ProdW:0] y;
    logic [ProdW:0] z;
    y = {1'b0, x} + {{(ProdW-ChanW+1){1'b0}}, HalfRound};
    z = y + {{ChanW{1'b0}}, y[ProdW:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return z[ProdW-1:ChanW];
  endfunction

endpackage

// ===== rtl/masked_paint_tint_blend.sv =====
// Channel | Direction | Handshake               | Payload
// in      | sink      | in_valid_i / in_stall_o  | src_red/green/blue/alpha, mask_red/green/blue
// out     | source    | out_valid_o / out_stall_i| out_red/green/blue/alpha
// cfg     | sink      | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// One beat enters per cycle unless in_stall_o is high.
// The path through the block is the lane pipeline: two multiplier stages each followed
// by a divide-by-255 stage, one blend multiply-add stage, and the merge register.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the
// configuration registers; datapath registers are left as they are.
// A stall on the output holds the merge register; bubbles upstream still fill,
// so in_stall_o only rises once every stage ahead holds a beat.
module masked_paint_tint_blend (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mptb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mptb_pkg::CfgDataW-1:0]     cfg_data_i,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mptb_pkg::ChanW-1:0]        src_red_i,
  input  logic [mptb_pkg::ChanW-1:0]        src_green_i,
  input  logic [mptb_pkg::ChanW-1:0]        src_blue_i,
  input  logic [mptb_pkg::ChanW-1:0]        src_alpha_i,
  input  logic [mptb_pkg::ChanW-1:0]        mask_red_i,
  input  logic [mptb_pkg::ChanW-1:0]        mask_green_i,
  input  logic [mptb_pkg::ChanW-1:0]        mask_blue_i,
  // pixel output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mptb_pkg::ChanW-1:0]        out_red_o,
  output logic [mptb_pkg::ChanW-1:0]        out_green_o,
  output logic [mptb_pkg::ChanW-1:0]        out_blue_o,
  output logic [mptb_pkg::ChanW-1:0]        out_alpha_o
);

  localparam int unsigned W     = mptb_pkg::ChanW;
  localparam int unsigned Depth = mptb_pkg::PipeDepth;

  // Configuration registers
  logic [mptb_pkg::ColorW-1:0] primary_q, secondary_q;
  logic                        mask_en_q, mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primary_q   <= '0;
      secondary_q <= '0;
      mask_en_q   <= 1'b0;
      mode_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mptb_pkg::cfg_idx_e'(cfg_idx_i))
        mptb_pkg::CfgPrimary:   primary_q   <= cfg_data_i;
        mptb_pkg::CfgSecondary: secondary_q <= cfg_data_i;
        mptb_pkg::CfgMaskEn:    mask_en_q   <= cfg_data_i[0];
        mptb_pkg::CfgMode:      mode_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Pipeline occupancy. go[k]: stage k may load this cycle, either because
  // it is empty or because its beat moves on. go[Depth] is the sink.
  logic [Depth-1:0] vld_q, vld_d;
  logic [Depth:0]   go;

  always_comb begin
    go[Depth] = ~out_stall_i;
    for (int k = Depth - 1; k >= 0; k--) begin
      go[k] = ~vld_q[k] | go[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < Depth; k++) begin
      if (go[k]) begin
        vld_d[k] = (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = ~go[0];
  assign out_valid_o = vld_q[Depth-1];

  // Lanes: one per colour channel, red in lane 0
  mptb_pkg::lane_en_t                                 lane_en;
  mptb_pkg::lane_cfg_t [mptb_pkg::NumLanes-1:0]       lane_cfg;
  logic [mptb_pkg::NumLanes-1:0][W-1:0]               lane_src, lane_mask;
  logic [mptb_pkg::NumLanes-1:0][mptb_pkg::ProdW-1:0] lane_sum;

  assign lane_en.ld = go[mptb_pkg::LaneStages-1:0];

  assign lane_src  = {src_blue_i, src_green_i, src_red_i};
  assign lane_mask = {mask_blue_i, mask_green_i, mask_red_i};

  for (genvar i = 0; i < mptb_pkg::NumLanes; i++) begin : g_lane
    // colours are packed red high, blue low
    assign lane_cfg[i].primary   = primary_q[(mptb_pkg::NumLanes-1-i)*W +: W];
    assign lane_cfg[i].secondary = secondary_q[(mptb_pkg::NumLanes-1-i)*W +: W];
    assign lane_cfg[i].mask_en   = mask_en_q;
    assign lane_cfg[i].body_mode = mode_q;

    mptb_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (lane_en),
      .cfg_i   (lane_cfg[i]),
      .src_i   (lane_src[i]),
      .alpha_i (src_alpha_i),
      .mask_i  (lane_mask[i]),
      .sum_o   (lane_sum[i])
    );
  end

  // Merge: final divide per lane into the output register
  mptb_merge u_merge (
    .clk_i   (clk_i),
    .ld_i    (go[Depth-1]),
    .sum_i   (lane_sum),
    .red_o   (out_red_o),
    .green_o (out_green_o),
    .blue_o  (out_blue_o),
    .alpha_o (out_alpha_o)
  );

  // Full pipeline with a stalled sink must refuse new beats
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && out_stall_i) |-> in_stall_o)
    else $error("beat accepted into a full, stalled pipeline");

  // An accepted beat lands in the first lane stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted beat lost at pipeline entry");

  // A first-stage beat that cannot advance is held
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && !go[1]) |=> vld_q[0])
    else $error("first-stage beat dropped while blocked");

  // A result not taken stays presented
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_red_o)
                                      && $stable(out_green_o) && $stable(out_blue_o)))
    else $error("stalled output beat changed");

endmodule

// ===== rtl/mptb_lane.sv =====
module mptb_lane (
  input  logic                           clk_i,
  input  mptb_pkg::lane_en_t             en_i,
  input  mptb_pkg::lane_cfg_t            cfg_i,
  input  logic [mptb_pkg::ChanW-1:0]     src_i,
  input  logic [mptb_pkg::ChanW-1:0]     alpha_i,
  input  logic [mptb_pkg::ChanW-1:0]     mask_i,
  output logic [mptb_pkg::ProdW-1:0]     sum_o
);

  localparam int unsigned W  = mptb_pkg::ChanW;
  localparam int unsigned PW = mptb_pkg::ProdW;

  // stage 1: interpolation products and preserve weight
  logic [PW-1:0] s1_mp_q, s1_ms_q;
  logic [W-1:0]  s1_src_q, s1_keep_q, s1_prim_q;
  logic          s1_interp_q;
  // stage 2: tint
  logic [W-1:0]  s2_tint_q, s2_src_q, s2_keep_q;
  // stage 3: tint and preserve products
  logic [PW-1:0] s3_pt_q, s3_pk_q;
  logic [W-1:0]  s3_keep_q;
  // stage 4: tinted channel
  logic [W-1:0]  s4_tinted_q, s4_keep_q;
  logic [PW-1:0] s4_pk_q;
  // stage 5: blend sum
  logic [PW-1:0] s5_sum_q;

  logic [W-1:0]  mask_eff, keep_d, tint_d;
  logic [PW-1:0] interp_sum, blend_sum;

  always_comb begin
    mask_eff = cfg_i.mask_en ? mask_i : '0;
    if (cfg_i.body_mode) begin
      keep_d = (mask_eff > alpha_i) ? mask_eff : alpha_i;
    end else begin
      keep_d = mask_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld[0]) begin
      s1_mp_q     <= PW'((mptb_pkg::FullScale - alpha_i) * cfg_i.primary);
      s1_ms_q     <= PW'(alpha_i * cfg_i.secondary);
      s1_src_q    <= src_i;
      s1_keep_q   <= keep_d;
      s1_prim_q   <= cfg_i.primary;
      s1_interp_q <= cfg_i.mask_en & ~cfg_i.body_mode;
    end
  end

  // weights sum to 255, so the interpolation stays within 255*255
  assign interp_sum = s1_mp_q + s1_ms_q;
  assign tint_d     = s1_interp_q ? mptb_pkg::div255_round(interp_sum) : s1_prim_q;

  always_ff @(posedge clk_i) begin
    if (en_i.ld[1]) begin
      s2_tint_q <= tint_d;
      s2_src_q  <= s1_src_q;
      s2_keep_q <= s1_keep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld[2]) begin
      s3_pt_q   <= PW'(s2_src_q * s2_tint_q);
      s3_pk_q   <= PW'(s2_src_q * s2_keep_q);
      s3_keep_q <= s2_keep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld[3]) begin
      s4_tinted_q <= mptb_pkg::div255_round(s3_pt_q);
      s4_pk_q     <= s3_pk_q;
      s4_keep_q   <= s3_keep_q;
    end
  end

  // bounded by 255*255, so it fits the product width
  assign blend_sum = s4_pk_q + PW'(s4_tinted_q * (mptb_pkg::FullScale - s4_keep_q));

  always_ff @(posedge clk_i) begin
    if (en_i.ld[4]) begin
      s5_sum_q <= blend_sum;
    end
  end

  assign sum_o = s5_sum_q;

endmodule

// ===== rtl/mptb_merge.sv =====
module mptb_merge (
  input  logic                                               clk_i,
  input  logic                                               ld_i,
  input  logic [mptb_pkg::NumLanes-1:0][mptb_pkg::ProdW-1:0] sum_i,
  output logic [mptb_pkg::ChanW-1:0]                         red_o,
  output logic [mptb_pkg::ChanW-1:0]                         green_o,
  output logic [mptb_pkg::ChanW-1:0]                         blue_o,
  output logic [mptb_pkg::ChanW-1:0]                         alpha_o
);

  logic [mptb_pkg::NumLanes-1:0][mptb_pkg::ChanW-1:0] pix_q;

  // lane 0 is red, lane 1 green, lane 2 blue
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      for (int i = 0; i < mptb_pkg::NumLanes; i++) begin
        pix_q[i] <= mptb_pkg::div255_round(sum_i[i]);
      end
    end
  end

  assign red_o   = pix_q[0];
  assign green_o = pix_q[1];
  assign blue_o  = pix_q[2];
  assign alpha_o = mptb_pkg::FullScale;

endmodule

// ===== verif/paint_blend_checker.sv =====
module paint_blend_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mptb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mptb_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [mptb_pkg::ChanW-1:0]    src_red_i,
  input  logic [mptb_pkg::ChanW-1:0]    src_green_i,
  input  logic [mptb_pkg::ChanW-1:0]    src_blue_i,
  input  logic [mptb_pkg::ChanW-1:0]    src_alpha_i,
  input  logic [mptb_pkg::ChanW-1:0]    mask_red_i,
  input  logic [mptb_pkg::ChanW-1:0]    mask_green_i,
  input  logic [mptb_pkg::ChanW-1:0]    mask_blue_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [mptb_pkg::ChanW-1:0]    out_red_i,
  input  logic [mptb_pkg::ChanW-1:0]    out_green_i,
  input  logic [mptb_pkg::ChanW-1:0]    out_blue_i,
  input  logic [mptb_pkg::ChanW-1:0]    out_alpha_i,
  output int unsigned                   fail_cnt_o,
  output int unsigned                   pending_o
);

  localparam int unsigned ChanW = mptb_pkg::ChanW;
  localparam int unsigned Scale = mptb_pkg::FullScale;
  localparam int unsigned Round = mptb_pkg::HalfRound;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } pixel_t;

  logic [mptb_pkg::ColorW-1:0] primary_q;
  logic [mptb_pkg::ColorW-1:0] secondary_q;
  logic                        mask_en_q;
  logic                        body_q;
  pixel_t                      expected_px_q[$];

  function automatic int unsigned scaled_round(int unsigned x);
    return (x + Round) / Scale;
  endfunction

  function automatic logic [ChanW-1:0] paint_channel(int unsigned src, int unsigned alpha,
                                                    int unsigned mask_smp,
                                                    int unsigned prim, int unsigned sec);
    int unsigned weight;
    int unsigned tint;
    int unsigned keep;
    int unsigned tinted;
    weight = mask_en_q ? mask_smp : 0;
    tint   = prim;
    if (!body_q) begin
      if (mask_en_q) tint = scaled_round((Scale - alpha) * prim + alpha * sec);
      keep = weight;
    end else begin
      keep = (weight > alpha) ? weight : alpha;
    end
    tinted = scaled_round(src * tint);
    return ChanW'(scaled_round(src * keep + tinted * (Scale - keep)));
  endfunction

  function automatic pixel_t paint_pixel();
    pixel_t px;
    px.red   = paint_channel(src_red_i, src_alpha_i, mask_red_i,
                             primary_q[23:16], secondary_q[23:16]);
    px.green = paint_channel(src_green_i, src_alpha_i, mask_green_i,
                             primary_q[15:8], secondary_q[15:8]);
    px.blue  = paint_channel(src_blue_i, src_alpha_i, mask_blue_i,
                             primary_q[7:0], secondary_q[7:0]);
    px.alpha = mptb_pkg::FullScale;
    return px;
  endfunction

  task automatic note_failure(string what, int unsigned exp_val, logic [ChanW-1:0] act);
    fail_cnt_o++;
    $error("%s mismatch: expected %0d, got %0d", what, exp_val, act);
  endtask

  task automatic compare_field(string what, logic [ChanW-1:0] exp_val, logic [ChanW-1:0] act);
    if (act !== exp_val) note_failure(what, exp_val, act);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t exp_px;
    if (!rst_ni) begin
      primary_q   = '0;
      secondary_q = '0;
      mask_en_q   = 1'b0;
      body_q      = 1'b0;
      expected_px_q.delete();
      fail_cnt_o  = 0;
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        unique case (mptb_pkg::cfg_idx_e'(cfg_idx_i))
          mptb_pkg::CfgPrimary:   primary_q   = cfg_data_i;
          mptb_pkg::CfgSecondary: secondary_q = cfg_data_i;
          mptb_pkg::CfgMaskEn:    mask_en_q   = cfg_data_i[0];
          mptb_pkg::CfgMode:      body_q      = cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_px_q.size() == 0) begin
          fail_cnt_o++;
          $error("output beat with nothing expected: %0d %0d %0d %0d",
                 out_red_i, out_green_i, out_blue_i, out_alpha_i);
        end else begin
          exp_px = expected_px_q.pop_front();
          compare_field("out_red", exp_px.red, out_red_i);
          compare_field("out_green", exp_px.green, out_green_i);
          compare_field("out_blue", exp_px.blue, out_blue_i);
          compare_field("out_alpha", exp_px.alpha, out_alpha_i);
        end
      end
      // append the prediction for the beat taken in at this edge
      if (in_valid_i && !in_stall_i) expected_px_q = {expected_px_q, paint_pixel()};
      pending_o = expected_px_q.size();
    end
  end

endmodule

// ===== verif/masked_paint_tint_blend_tb.sv =====
module masked_paint_tint_blend_tb;

  localparam int unsigned ChanW    = mptb_pkg::ChanW;
  localparam int unsigned ColorW   = mptb_pkg::ColorW;
  localparam int unsigned CfgDataW = mptb_pkg::CfgDataW;
  localparam int unsigned CfgIdxW  = mptb_pkg::CfgIdxW;
  // junk bits above a flag in its register word
  localparam int unsigned PadW     = CfgDataW - 1;

  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 10;
  // idle cycles (no beat in or out, no register write) before giving up
  localparam int unsigned IdleLimit   = 2000;
  // length of the deliberate output hold-off
  localparam int unsigned HoldCycles  = 48;
  localparam int unsigned NumPhases   = 10;
  localparam int unsigned PhaseItems  = 48;

  localparam logic ModeTwoTone = 1'b0;
  localparam logic ModeBody    = 1'b1;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ChanW-1:0]    src_red_i, src_green_i, src_blue_i, src_alpha_i;
  logic [ChanW-1:0]    mask_red_i, mask_green_i, mask_blue_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ChanW-1:0]    out_red_o, out_green_o, out_blue_o, out_alpha_o;

  int unsigned fail_cnt;
  int unsigned pending_cnt;

  // receiver and watchdog state; stall_pct and hold_seq are set by stimulus
  int unsigned stall_pct = 0;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  always #HalfPeriod clk_i = ~clk_i;

  masked_paint_tint_blend uut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .src_red_i,
    .src_green_i,
    .src_blue_i,
    .src_alpha_i,
    .mask_red_i,
    .mask_green_i,
    .mask_blue_i,
    .out_valid_o,
    .out_stall_i,
    .out_red_o,
    .out_green_o,
    .out_blue_o,
    .out_alpha_o
  );

  // The checker sees the same pins as the block, predicts every beat taken in
  // and scores every beat handed out.
  paint_blend_checker chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_i   (in_stall_o),
    .src_red_i,
    .src_green_i,
    .src_blue_i,
    .src_alpha_i,
    .mask_red_i,
    .mask_green_i,
    .mask_blue_i,
    .out_valid_i  (out_valid_o),
    .out_stall_i,
    .out_red_i    (out_red_o),
    .out_green_i  (out_green_o),
    .out_blue_i   (out_blue_o),
    .out_alpha_i  (out_alpha_o),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending_cnt)
  );

  // Receiver: stall at the phase's random rate, unless a hold-off has been
  // requested, in which case stall solidly until the hold-off of HoldCycles
  // runs out, so that the pipeline fills and the block pushes back on its input.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: count cycles in which nothing moves; reset counts as activity.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o)
        || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one pixel beat and hold it until the block takes it. Valid is left
  // high so that back-to-back beats need no second assignment in a step.
  task automatic offer_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g, logic [ChanW-1:0] b,
                             logic [ChanW-1:0] a, logic [ChanW-1:0] mr,
                             logic [ChanW-1:0] mg, logic [ChanW-1:0] mb);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    src_red_i    <= r;
    src_green_i  <= g;
    src_blue_i   <= b;
    src_alpha_i  <= a;
    mask_red_i   <= mr;
    mask_green_i <= mg;
    mask_blue_i  <= mb;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_input(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop valid and wait until the checker holds no outstanding prediction.
  task automatic drain_pixels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
  endtask

  // Write all four registers on consecutive cycles, then release the port.
  task automatic load_paint(logic [ColorW-1:0] prim, logic [ColorW-1:0] sec,
                            logic [CfgDataW-1:0] mask_word, logic [CfgDataW-1:0] mode_word);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= mptb_pkg::CfgPrimary;
    cfg_data_i <= prim;
    @(negedge clk_i);
    cfg_idx_i  <= mptb_pkg::CfgSecondary;
    cfg_data_i <= sec;
    @(negedge clk_i);
    cfg_idx_i  <= mptb_pkg::CfgMaskEn;
    cfg_data_i <= mask_word;
    @(negedge clk_i);
    cfg_idx_i  <= mptb_pkg::CfgMode;
    cfg_data_i <= mode_word;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Channel value weighted towards the ends of the range.
  function automatic logic [ChanW-1:0] pick_chan();
    unique case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ChanW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [ColorW-1:0] pick_color();
    unique case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      default: return ColorW'($urandom);
    endcase
  endfunction

  // Register word with junk in the upper bits; only bit 0 should count.
  function automatic logic [CfgDataW-1:0] flag_word(logic flag);
    return {PadW'($urandom), flag};
  endfunction

  initial begin
    int unsigned     ph;
    int unsigned     sent;
    int unsigned     burst;
    int unsigned     gap_max;
    logic            mask_bit;
    logic            mode_bit;
    logic [ColorW-1:0] prim;
    logic [ColorW-1:0] sec;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = mptb_pkg::CfgPrimary;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    src_red_i    = '0;
    src_green_i  = '0;
    src_blue_i   = '0;
    src_alpha_i  = '0;
    mask_red_i   = '0;
    mask_green_i = '0;
    mask_blue_i  = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Two-tone, no mask: tint is plain primary, mask samples must be ignored.
    load_paint(24'hFFFFFF, 24'h000000, flag_word(1'b0), flag_word(ModeTwoTone));
    offer_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    offer_pixel(8'd255, 8'd128, 8'd1, 8'd77, 8'd255, 8'd200, 8'd9);
    offer_pixel(8'd200, 8'd100, 8'd50, 8'd255, 8'd0, 8'd0, 8'd0);
    drain_pixels();

    // Two-tone with mask: alpha sweeps the tint between the two colours.
    load_paint(24'h00FF80, 24'hFF0080, flag_word(1'b1), flag_word(ModeTwoTone));
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd128, 8'd255, 8'd255, 8'd255);
    offer_pixel(8'd180, 8'd60, 8'd240, 8'd128, 8'd0, 8'd128, 8'd255);
    offer_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd128);
    drain_pixels();

    // Body paint without mask: alpha alone is the preserve weight.
    load_paint(24'h123456, 24'hFFFFFF, flag_word(1'b0), flag_word(ModeBody));
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255);
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    offer_pixel(8'd90, 8'd170, 8'd33, 8'd100, 8'd200, 8'd10, 8'd255);
    offer_pixel(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    drain_pixels();

    // Body paint with mask: preserve is the larger of mask and alpha.
    load_paint(24'hFFFFFF, 24'h000000, flag_word(1'b1), flag_word(ModeBody));
    offer_pixel(8'd200, 8'd200, 8'd200, 8'd50, 8'd150, 8'd50, 8'd10);
    offer_pixel(8'd200, 8'd200, 8'd200, 8'd150, 8'd255, 8'd150, 8'd0);
    offer_pixel(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd255, 8'd255);
    offer_pixel(8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);

    // Random phases: each one drains, reloads the paint and streams bursts.
    // The first four walk every mode/mask combination; the rest pick freely.
    for (ph = 0; ph < NumPhases; ph++) begin
      drain_pixels();
      prim     = (ph == 0) ? '0 : (ph == 1) ? '1 : pick_color();
      sec      = (ph == 0) ? '1 : (ph == 1) ? '0 : pick_color();
      mask_bit = (ph < 4) ? ph[0] : 1'($urandom_range(1));
      mode_bit = (ph < 4) ? ph[1] : 1'($urandom_range(1));
      load_paint(prim, sec, flag_word(mask_bit), flag_word(mode_bit));

      unique case (ph % 4)
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      gap_max = 6;
      // on two phases hold the output off and keep offering beats back to back
      if (ph == 2 || ph == 7) begin
        gap_max = 0;
        hold_seq++;
      end

      sent = 0;
      while (sent < PhaseItems) begin
        burst = $urandom_range(16, 1);
        while (burst != 0 && sent < PhaseItems) begin
          offer_pixel(pick_chan(), pick_chan(), pick_chan(), pick_chan(),
                      pick_chan(), pick_chan(), pick_chan());
          burst--;
          sent++;
        end
        idle_input($urandom_range(gap_max, 0));
      end
    end

    // Let everything out, then allow for the pipeline to settle.
    drain_pixels();
    stall_pct = 0;
    repeat (2 * mptb_pkg::PipeDepth) @(negedge clk_i);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== masked_paint_tint_blend.f =====
rtl/mptb_pkg.sv
rtl/mptb_lane.sv
rtl/mptb_merge.sv
rtl/masked_paint_tint_blend.sv
verif/paint_blend_checker.sv
verif/masked_paint_tint_blend_tb.sv
